@@ src/fsn_pkg.sv @@
`timescale 1ns / 1ps
package fsn_pkg;

   localparam logic [31:0] MAGIC_GUESS = 32'h5f375a86;
   localparam logic [31:0] HALF_F      = 32'h3f000000;
   localparam logic [31:0] ONE_HALF_F  = 32'h3fc00000;
   localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
   localparam logic [7:0]  EXP_ALL1    = 8'hff;

   // reciprocal divider: quotient bits and bits retired per stage
   localparam int RECIP_QBITS  = 27;
   localparam int RECIP_STEP   = 3;
   localparam int RECIP_STAGES = RECIP_QBITS / RECIP_STEP;

   // operand with hidden bit made explicit and subnormals normalized
   typedef struct packed {
      logic        sign;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic [9:0]  exp;   // unbiased, two's complement
      logic [23:0] man;   // 1.23 fixed point when finite and nonzero
   } fsn_unpacked_type;

   // leading zero count of a 27-bit word, 27 when all zero
   function automatic logic [4:0] lzc27(logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic fsn_unpacked_type unpack_norm(logic [31:0] b);
      fsn_unpacked_type u;
      logic [4:0]       lz;
      u.sign    = b[31];
      u.is_nan  = (b[30:23] == EXP_ALL1) && (b[22:0] != 23'd0);
      u.is_inf  = (b[30:23] == EXP_ALL1) && (b[22:0] == 23'd0);
      u.is_zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
      lz = lzc27({1'b0, b[22:0], 3'b111});
      if (b[30:23] != 8'd0) begin
         u.man = {1'b1, b[22:0]};
         u.exp = {2'b00, b[30:23]} - 10'd127;
      end else begin
         u.man = {1'b0, b[22:0]} << lz;
         u.exp = 10'h382 - {5'd0, lz};
      end
      return u;
   endfunction

   // value is m / 2^47 * 2^e with m[47] set; round to nearest even and pack
   function automatic logic [31:0] round_pack(logic sign, logic signed [10:0] e,
                                              logic [47:0] m);
      logic signed [10:0] be;
      logic signed [10:0] sh;
      logic [5:0]         sh6;
      logic [47:0]        shm;
      logic               lost;
      logic [23:0]        mant;
      logic               g;
      logic               st;
      logic               inc;
      logic [7:0]         ef;
      logic [30:0]        mag;
      logic [31:0]        res;
      be = e + 11'sd127;
      sh = 11'sd1 - be;
      sh6 = 6'd0;
      shm = m;
      lost = 1'b0;
      mant = 24'd0;
      g = 1'b0;
      st = 1'b0;
      ef = 8'd0;
      if (be >= 11'sd1) begin
         mant = m[47:24];
         g = m[23];
         st = |m[22:0];
         ef = be[7:0];
      end else if (sh > 11'sd25) begin
         st = 1'b1;
      end else begin
         sh6 = sh[5:0];
         shm = m >> sh6;
         lost = |(m & ~({48{1'b1}} << sh6));
         mant = shm[47:24];
         g = shm[23];
         st = (|shm[22:0]) | lost;
      end
      inc = g & (st | mant[0]);
      mag = {ef, mant[22:0]} + {30'd0, inc};
      if (be >= 11'sd255) begin
         res = {sign, EXP_ALL1, 23'd0};
      end else begin
         res = {sign, mag};
      end
      return res;
   endfunction

endpackage

@@ src/fsn_fmul.sv @@
`timescale 1ns / 1ps
module fsn_fmul #(
   parameter int SW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [31:0]   a_bits,
   input  logic [31:0]   b_bits,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [31:0]   z_bits,
   output logic [SW-1:0] out_side
);
   import fsn_pkg::*;

   fsn_unpacked_type ua, ub;
   logic               adv1, adv2;
   logic               v1_ff, v2_ff;
   logic               sign1_ff, nan1_ff, inf1_ff, zero1_ff;
   logic signed [10:0] esum1_ff;
   logic [47:0]        prod1_ff;
   logic [SW-1:0]      side1_ff, side2_ff;
   logic [31:0]        z2_ff, z2_in;
   logic signed [10:0] e2;
   logic [47:0]        m2;

   assign adv1 = !v1_ff || adv2;
   assign adv2 = !v2_ff || out_ready;
   assign in_ready = adv1;

   // stage 1: unpack and mantissa product
   always_comb begin
      ua = unpack_norm(a_bits);
      ub = unpack_norm(b_bits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= in_valid;
      end
      if (adv1) begin
         sign1_ff <= ua.sign ^ ub.sign;
         nan1_ff  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero) |
                     (ua.is_zero & ub.is_inf);
         inf1_ff  <= ua.is_inf | ub.is_inf;
         zero1_ff <= ua.is_zero | ub.is_zero;
         esum1_ff <= $signed({ua.exp[9], ua.exp}) + $signed({ub.exp[9], ub.exp});
         prod1_ff <= ua.man * ub.man;
         side1_ff <= in_side;
      end
   end

   // stage 2: normalize by one place, round and pack
   always_comb begin
      if (prod1_ff[47]) begin
         m2 = prod1_ff;
         e2 = esum1_ff + 11'sd1;
      end else begin
         m2 = {prod1_ff[46:0], 1'b0};
         e2 = esum1_ff;
      end
      if (nan1_ff) begin
         z2_in = CANON_NAN;
      end else if (inf1_ff) begin
         z2_in = {sign1_ff, EXP_ALL1, 23'd0};
      end else if (zero1_ff) begin
         z2_in = {sign1_ff, 31'd0};
      end else begin
         z2_in = round_pack(sign1_ff, e2, m2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         z2_ff    <= z2_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign z_bits    = z2_ff;
   assign out_side  = side2_ff;

endmodule

@@ src/fsn_fadd.sv @@
`timescale 1ns / 1ps
module fsn_fadd #(
   parameter int SW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [31:0]   a_bits,
   input  logic [31:0]   b_bits,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [31:0]   z_bits,
   output logic [SW-1:0] out_side
);
   import fsn_pkg::*;

   logic          adv1, adv2, adv3;
   logic          v1_ff, v2_ff, v3_ff;
   logic          a_nan, b_nan, a_inf, b_inf, swap;
   logic [31:0]   big, sml;
   logic [7:0]    ebig, esml, d;
   logic [23:0]   mbig, msml;
   logic [26:0]   ext, align;
   logic          nan1_ff, inf1_ff, sign1_ff, sub1_ff;
   logic [7:0]    e1_ff;
   logic [26:0]   mb1_ff, ms1_ff;
   logic [SW-1:0] side1_ff, side2_ff, side3_ff;
   logic          nan2_ff, inf2_ff, sign2_ff, sub2_ff;
   logic [7:0]    e2_ff;
   logic [27:0]   sum2_ff, sum2_in;
   logic [31:0]   z3_ff, z3_in;
   logic [26:0]   n;
   logic [8:0]    eo;
   logic [4:0]    lz, sh;
   logic [7:0]    lim, ef;
   logic [23:0]   mant;
   logic          g, st, inc;
   logic [30:0]   mag;

   assign adv1 = !v1_ff || adv2;
   assign adv2 = !v2_ff || adv3;
   assign adv3 = !v3_ff || out_ready;
   assign in_ready = adv1;

   // stage 1: order by magnitude and align the smaller operand
   always_comb begin
      a_nan = (a_bits[30:23] == EXP_ALL1) && (a_bits[22:0] != 23'd0);
      b_nan = (b_bits[30:23] == EXP_ALL1) && (b_bits[22:0] != 23'd0);
      a_inf = (a_bits[30:23] == EXP_ALL1) && (a_bits[22:0] == 23'd0);
      b_inf = (b_bits[30:23] == EXP_ALL1) && (b_bits[22:0] == 23'd0);
      swap = b_bits[30:0] > a_bits[30:0];
      big = swap ? b_bits : a_bits;
      sml = swap ? a_bits : b_bits;
      ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mbig = {big[30:23] != 8'd0, big[22:0]};
      msml = {sml[30:23] != 8'd0, sml[22:0]};
      d = ebig - esml;
      ext = {msml, 3'b000};
      if (d >= 8'd27) begin
         align = {26'd0, |msml};
      end else begin
         align = (ext >> d[4:0]) | {26'd0, |(ext & ~({27{1'b1}} << d[4:0]))};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= in_valid;
      end
      if (adv1) begin
         nan1_ff  <= a_nan | b_nan | (a_inf & b_inf & (a_bits[31] != b_bits[31]));
         inf1_ff  <= a_inf | b_inf;
         sign1_ff <= big[31];
         sub1_ff  <= a_bits[31] ^ b_bits[31];
         e1_ff    <= ebig;
         mb1_ff   <= {mbig, 3'b000};
         ms1_ff   <= align;
         side1_ff <= in_side;
      end
   end

   // stage 2: add or subtract magnitudes
   assign sum2_in = sub1_ff ? ({1'b0, mb1_ff} - {1'b0, ms1_ff})
                            : ({1'b0, mb1_ff} + {1'b0, ms1_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
         sign2_ff <= sign1_ff;
         sub2_ff  <= sub1_ff;
         e2_ff    <= e1_ff;
         sum2_ff  <= sum2_in;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: normalize, round and pack
   always_comb begin
      lz = lzc27(sum2_ff[26:0]);
      lim = e2_ff - 8'd1;
      if (sum2_ff[27]) begin
         sh = 5'd0;
         n = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         eo = {1'b0, e2_ff} + 9'd1;
      end else begin
         sh = ({3'd0, lz} < lim) ? lz : lim[4:0];
         n = sum2_ff[26:0] << sh;
         eo = {1'b0, e2_ff} - {4'd0, sh};
      end
      ef = n[26] ? eo[7:0] : 8'd0;
      mant = n[26:3];
      g = n[2];
      st = n[1] | n[0];
      inc = g & (st | mant[0]);
      mag = {ef, mant[22:0]} + {30'd0, inc};
      if (nan2_ff) begin
         z3_in = CANON_NAN;
      end else if (inf2_ff || (eo >= 9'd255)) begin
         z3_in = {sign2_ff, EXP_ALL1, 23'd0};
      end else if (sum2_ff == 28'd0) begin
         z3_in = {sign2_ff & !sub2_ff, 31'd0};
      end else begin
         z3_in = {sign2_ff, mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= v2_ff;
      end
      if (adv3) begin
         z3_ff    <= z3_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign z_bits    = z3_ff;
   assign out_side  = side3_ff;

endmodule

@@ src/fsn_newton.sv @@
`timescale 1ns / 1ps
module fsn_newton (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] y_bits,
   input  logic [31:0] half_bits,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] y_next_bits,
   output logic [31:0] half_next_bits
);
   import fsn_pkg::*;

   logic        v1, r1, v2, r2, v3, r3;
   logic [31:0] t1, t2, c3;
   logic [63:0] s1, s2, s3;

   // t = half * y
   fsn_fmul #(.SW(64)) u_mul_hy (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_ready(in_ready),
      .a_bits(half_bits), .b_bits(y_bits), .in_side({y_bits, half_bits}),
      .out_valid(v1), .out_ready(r1), .z_bits(t1), .out_side(s1)
   );

   // t = t * y
   fsn_fmul #(.SW(64)) u_mul_ty (
      .clock(clock), .reset(reset),
      .in_valid(v1), .in_ready(r1),
      .a_bits(t1), .b_bits(s1[63:32]), .in_side(s1),
      .out_valid(v2), .out_ready(r2), .z_bits(t2), .out_side(s2)
   );

   // t = 1.5 - t
   fsn_fadd #(.SW(64)) u_sub (
      .clock(clock), .reset(reset),
      .in_valid(v2), .in_ready(r2),
      .a_bits(ONE_HALF_F), .b_bits({~t2[31], t2[30:0]}), .in_side(s2),
      .out_valid(v3), .out_ready(r3), .z_bits(c3), .out_side(s3)
   );

   // y = y * t
   fsn_fmul #(.SW(32)) u_mul_yt (
      .clock(clock), .reset(reset),
      .in_valid(v3), .in_ready(r3),
      .a_bits(s3[63:32]), .b_bits(c3), .in_side(s3[31:0]),
      .out_valid(out_valid), .out_ready(out_ready),
      .z_bits(y_next_bits), .out_side(half_next_bits)
   );

endmodule

@@ src/fsn_recip.sv @@
`timescale 1ns / 1ps
module fsn_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] y_bits,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] r_bits
);
   import fsn_pkg::*;

   localparam int NS = RECIP_STAGES;

   logic [NS+1:0] adv;
   logic          v_ff [NS+1];
   logic [24:0]   rem_ff [NS+1];
   logic [26:0]   quo_ff [NS+1];
   logic [23:0]   dvs_ff [NS+1];
   logic [9:0]    exp_ff [NS+1];
   logic          sgn_ff [NS+1];
   logic          spc_ff [NS+1];
   logic [31:0]   spv_ff [NS+1];
   fsn_unpacked_type u;
   logic          spc_in;
   logic [31:0]   spv_in;
   logic          ov_ff;
   logic [31:0]   r_ff, r_in;
   logic signed [10:0] e11, er;
   logic [47:0]   m;

   // advance enables, worked back from the output register
   always_comb begin
      adv[NS+1] = !ov_ff || out_ready;
      for (int k = NS; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end
   assign in_ready = adv[0];

   // stage 0: unpack divisor, pick out zero, infinity and nan
   always_comb begin
      u = unpack_norm(y_bits);
      spc_in = u.is_zero | u.is_inf | u.is_nan;
      if (u.is_nan) begin
         spv_in = CANON_NAN;
      end else if (u.is_zero) begin
         spv_in = {u.sign, EXP_ALL1, 23'd0};
      end else begin
         spv_in = {u.sign, 31'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= in_valid;
      end
      if (adv[0]) begin
         rem_ff[0] <= 25'h0800000;
         quo_ff[0] <= 27'd0;
         dvs_ff[0] <= u.man;
         exp_ff[0] <= u.exp;
         sgn_ff[0] <= u.sign;
         spc_ff[0] <= spc_in;
         spv_ff[0] <= spv_in;
      end
   end

   // restoring division of 1.0 by the mantissa, a few quotient bits per stage
   for (genvar k = 1; k <= NS; k++) begin : g_div
      logic [24:0] r_in;
      logic [26:0] q_in;

      always_comb begin
         r_in = rem_ff[k-1];
         q_in = quo_ff[k-1];
         for (int j = 0; j < RECIP_STEP; j++) begin
            if (r_in >= {1'b0, dvs_ff[k-1]}) begin
               r_in = r_in - {1'b0, dvs_ff[k-1]};
               q_in = {q_in[25:0], 1'b1};
            end else begin
               q_in = {q_in[25:0], 1'b0};
            end
            r_in = {r_in[23:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (adv[k]) begin
            rem_ff[k] <= r_in;
            quo_ff[k] <= q_in;
            dvs_ff[k] <= dvs_ff[k-1];
            exp_ff[k] <= exp_ff[k-1];
            sgn_ff[k] <= sgn_ff[k-1];
            spc_ff[k] <= spc_ff[k-1];
            spv_ff[k] <= spv_ff[k-1];
         end
      end
   end

   // final stage: place the quotient, round and pack
   always_comb begin
      e11 = $signed({exp_ff[NS][9], exp_ff[NS]});
      if (quo_ff[NS][26]) begin
         m = {1'b1, 47'd0};
         er = -e11;
      end else begin
         m = {quo_ff[NS][25:0], rem_ff[NS] != 25'd0, 21'd0};
         er = -e11 - 11'sd1;
      end
      r_in = spc_ff[NS] ? spv_ff[NS] : round_pack(sgn_ff[NS], er, m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv[NS+1]) begin
         ov_ff <= v_ff[NS];
      end
      if (adv[NS+1]) begin
         r_ff <= r_in;
      end
   end

   assign out_valid = ov_ff;
   assign r_bits    = r_ff;

endmodule

@@ src/fast_sqrt_magic_newton_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// req     | in        | req_valid, req_stall | req_operand_bits[31:0]  float32 operand
// rsp     | out       | rsp_valid, rsp_stall | rsp_root_bits[31:0]     float32 approx root
//
// one word accepted per clock unless req_stall; path: guess register, halving multiply,
// three newton steps of multiply, multiply, subtract, multiply, then the reciprocal
// the reciprocal is a restoring divider retiring three quotient bits per stage
// reset clears only the stage valid bits; no state is kept between words
// each stage moves when it is empty or the next one moves, so bubbles close up while
// rsp is stalled and req_stall rises only once every stage holds a word
module fast_sqrt_magic_newton_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_root_bits
);
   import fsn_pkg::*;

   logic        v0_ff, adv0;
   logic [31:0] x0_ff, g0_ff, g0_in;
   logic        hm_ready, hm_valid;
   logic [31:0] half_h, y_h;
   logic        v_n [4];
   logic        r_n [4];
   logic [31:0] y_n [4];
   logic [31:0] h_n [4];
   logic        rc_ready;

   assign adv0 = !v0_ff || hm_ready;
   assign req_stall = !adv0;

   // initial guess from the integer trick
   assign g0_in = MAGIC_GUESS - {req_operand_bits[31], req_operand_bits[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv0) begin
         v0_ff <= req_valid;
      end
      if (adv0) begin
         x0_ff <= req_operand_bits;
         g0_ff <= g0_in;
      end
   end

   // half = 0.5 * x
   fsn_fmul #(.SW(32)) u_half (
      .clock(clock), .reset(reset),
      .in_valid(v0_ff), .in_ready(hm_ready),
      .a_bits(x0_ff), .b_bits(HALF_F), .in_side(g0_ff),
      .out_valid(hm_valid), .out_ready(r_n[0]), .z_bits(half_h), .out_side(y_h)
   );

   assign v_n[0] = hm_valid;
   assign y_n[0] = y_h;
   assign h_n[0] = half_h;

   // three refinement steps
   for (genvar i = 0; i < 3; i++) begin : g_step
      fsn_newton u_step (
         .clock(clock), .reset(reset),
         .in_valid(v_n[i]), .in_ready(r_n[i]),
         .y_bits(y_n[i]), .half_bits(h_n[i]),
         .out_valid(v_n[i+1]), .out_ready(r_n[i+1]),
         .y_next_bits(y_n[i+1]), .half_next_bits(h_n[i+1])
      );
   end

   assign r_n[3] = rc_ready;

   // root = 1 / y
   fsn_recip u_recip (
      .clock(clock), .reset(reset),
      .in_valid(v_n[3]), .in_ready(rc_ready),
      .y_bits(y_n[3]),
      .out_valid(rsp_valid), .out_ready(!rsp_stall), .r_bits(rsp_root_bits)
   );

`ifndef ASSERT_OFF
   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_bits[30:23] == EXP_ALL1) && (rsp_root_bits[22:0] != 23'd0)
      |-> rsp_root_bits == CANON_NAN)
      else $error("result nan not canonical");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v0_ff && !hm_ready)
      else $error("input stalled with room in the first stage");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      v0_ff && !hm_ready |=> v0_ff && $stable(x0_ff) && $stable(g0_ff))
      else $error("first stage word lost while blocked");

   a_guess: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> g0_ff == MAGIC_GUESS - {x0_ff[31], x0_ff[31:1]})
      else $error("guess register does not match operand");
`endif

endmodule
